>>> rtl/core/rsa_pkg.sv
package rsa_pkg;

    // Sample and count widths; the accumulator widths follow from them.
    localparam int SAMPLE_BITS       = 16;
    localparam int COUNT_BITS        = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SUM_X_W  = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int SUM_X2_W = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int SUM_XY_W = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_W   = 2 * SAMPLE_BITS;

    // Merge fields of the request.
    localparam int MERGE_COUNT_W = 16;
    localparam int MERGE_SX_W    = 33;
    localparam int MERGE_SX2_W   = 47;
    localparam int MERGE_SXY_W   = 48;

    // Result fields.
    localparam int SLOPE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FUNC_W   = 3;

    // Serial multiplier: the multiplier operand is a signed value wide enough for
    // every sum, and the accumulator holds both covariance and variance exactly.
    localparam int MUL_B_W = SUM_XY_W + 1;
    localparam int ACC_W   = 2 * SUM_X_W + 1;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 3'd0,
        FUNC_DROP  = 3'd1,
        FUNC_MERGE = 3'd2,
        FUNC_EVAL  = 3'd3,
        FUNC_CLEAR = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_FLAT = 2'd2,
        STATUS_SAT  = 2'd3
    } status_t;

    // One classified request as it travels through the queue.
    typedef struct packed {
        func_t                          func;
        logic signed [SAMPLE_BITS-1:0]  x_value;
        logic signed [SAMPLE_BITS-1:0]  y_value;
        logic [PROD_W-1:0]              x_sq;
        logic signed [PROD_W-1:0]       x_y;
        logic [MERGE_COUNT_W-1:0]       merge_count;
        logic signed [MERGE_SX_W-1:0]   merge_sum_x;
        logic [MERGE_SX2_W-1:0]         merge_sum_x2;
        logic signed [MERGE_SX_W-1:0]   merge_sum_y;
        logic signed [MERGE_SXY_W-1:0]  merge_sum_xy;
    } entry_t;

    // Queue occupancy as seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/core/rsa_in_if.sv
interface rsa_in_if import rsa_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic [FUNC_W-1:0]             func;
    logic signed [SAMPLE_BITS-1:0] x_value;
    logic signed [SAMPLE_BITS-1:0] y_value;
    logic [MERGE_COUNT_W-1:0]      merge_count;
    logic signed [MERGE_SX_W-1:0]  merge_sum_x;
    logic [MERGE_SX2_W-1:0]        merge_sum_x2;
    logic signed [MERGE_SX_W-1:0]  merge_sum_y;
    logic signed [MERGE_SXY_W-1:0] merge_sum_xy;

    modport source (
        output valid, func, x_value, y_value, merge_count,
               merge_sum_x, merge_sum_x2, merge_sum_y, merge_sum_xy,
        input  ready
    );

    modport sink (
        input  valid, func, x_value, y_value, merge_count,
               merge_sum_x, merge_sum_x2, merge_sum_y, merge_sum_xy,
        output ready
    );

endinterface

>>> rtl/core/rsa_out_if.sv
interface rsa_out_if import rsa_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope;
    logic [STATUS_W-1:0]       status;

    modport source (
        output valid, slope, status,
        input  ready
    );

    modport sink (
        input  valid, slope, status,
        output ready
    );

endinterface

>>> rtl/core/rsa_front.sv
module rsa_front import rsa_pkg::*; (
    rsa_in_if.sink   sample,
    input  qstat_t   qstat,
    output logic     push,
    output entry_t   entry
);

    logic                     known_func;
    logic signed [PROD_W-1:0] prod_xx;
    logic signed [PROD_W-1:0] prod_xy;

    // Unused function codes are taken and dropped here; they never reach the back.
    always_comb
    begin
        known_func = (sample.func == FUNC_ADD)   || (sample.func == FUNC_DROP) ||
                     (sample.func == FUNC_MERGE) || (sample.func == FUNC_EVAL) ||
                     (sample.func == FUNC_CLEAR);
    end

    assign sample.ready = !qstat.full;
    assign push         = sample.valid && !qstat.full && known_func;

    // Sample products are formed once on the way in, so the back only adds.
    assign prod_xx = sample.x_value * sample.x_value;
    assign prod_xy = sample.x_value * sample.y_value;

    // Pack the classified request for the queue.
    always_comb
    begin
        entry.func         = func_t'(sample.func);
        entry.x_value      = sample.x_value;
        entry.y_value      = sample.y_value;
        entry.x_sq         = prod_xx;
        entry.x_y          = prod_xy;
        entry.merge_count  = sample.merge_count;
        entry.merge_sum_x  = sample.merge_sum_x;
        entry.merge_sum_x2 = sample.merge_sum_x2;
        entry.merge_sum_y  = sample.merge_sum_y;
        entry.merge_sum_xy = sample.merge_sum_xy;
    end

endmodule

>>> rtl/core/rsa_queue.sv
module rsa_queue import rsa_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_entry,
    input  logic   pop,
    output entry_t head,
    output qstat_t qstat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    assign head        = mem[rd_ptr_reg];
    assign qstat.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);

endmodule

>>> rtl/core/rsa_back.sv
module rsa_back import rsa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  qstat_t     qstat,
    output logic       pop,
    rsa_out_if.source  result
);

    localparam int NUM_W     = ACC_W + FRACTION_BITS;
    localparam int QUOT_W    = SLOPE_W + 1;
    localparam int MB_CNT_W  = $clog2(MUL_B_W);
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [QUOT_W:0] NEG_LIMIT = (QUOT_W + 1)'(1) << (SLOPE_W - 1);
    localparam logic [QUOT_W:0] POS_LIMIT = NEG_LIMIT - 1'b1;
    localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W - 1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_MUL = 4'b0010,
        ST_DIV = 4'b0100,
        ST_FIN = 4'b1000
    } state_t;

    // Aggregate state.
    logic [COUNT_BITS-1:0]      count_reg,  count_next;
    logic signed [SUM_X_W-1:0]  sum_x_reg,  sum_x_next;
    logic [SUM_X2_W-1:0]        sum_x2_reg, sum_x2_next;
    logic signed [SUM_X_W-1:0]  sum_y_reg,  sum_y_next;
    logic signed [SUM_XY_W-1:0] sum_xy_reg, sum_xy_next;

    // Evaluation control.
    state_t                     state_reg, state_next;
    logic [1:0]                 pass_reg, pass_next;
    logic [MB_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                       early_reg, early_next;
    status_t                    early_code_reg, early_code_next;
    logic                       out_valid_reg, out_valid_next;

    // Evaluation datapath.
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [ACC_W-1:0]           cov_reg, cov_next;
    logic [ACC_W-1:0]           mcand_reg, mcand_next;
    logic [MUL_B_W-1:0]         mplier_reg, mplier_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic [ACC_W-1:0]           rem_reg, rem_next;
    logic [QUOT_W-1:0]          quot_reg, quot_next;
    logic                       ovf_reg, ovf_next;
    logic                       neg_reg, neg_next;
    logic [SLOPE_W-1:0]         slope_reg, slope_next;
    status_t                    status_reg, status_next;

    // Combinational helpers.
    logic [1:0]                 pass_sel;
    logic [ACC_W-1:0]           op_mcand;
    logic [MUL_B_W-1:0]         op_mplier;
    logic [ACC_W-1:0]           mul_term;
    logic                       mul_last;
    logic [ACC_W-1:0]           mul_sum;
    logic                       var_pos;
    logic [ACC_W-1:0]           cov_abs;
    logic [ACC_W:0]             div_shift;
    logic [ACC_W:0]             div_diff;
    logic                       div_ge;
    logic                       div_last;
    logic                       rnd;
    logic [QUOT_W:0]            quot_rnd;
    logic [QUOT_W:0]            quot_neg;
    logic [SLOPE_W-1:0]         fin_slope;
    status_t                    fin_status;
    logic                       out_free;
    logic [COUNT_BITS:0]        merge_total;

    // Operands of the next multiply pass: N*Sxy, Sx*Sy, N*Sxx, Sx*Sx.
    always_comb
    begin
        pass_sel = (state_reg == ST_RUN) ? 2'd0 : pass_reg + 2'd1;
        unique case (pass_sel)
            2'd0:
            begin
                op_mcand  = ACC_W'(count_reg);
                op_mplier = MUL_B_W'(sum_xy_reg);
            end
            2'd1:
            begin
                op_mcand  = ACC_W'(sum_x_reg);
                op_mplier = MUL_B_W'(sum_y_reg);
            end
            2'd2:
            begin
                op_mcand  = ACC_W'(count_reg);
                op_mplier = MUL_B_W'(sum_x2_reg);
            end
            2'd3:
            begin
                op_mcand  = ACC_W'(sum_x_reg);
                op_mplier = MUL_B_W'(sum_x_reg);
            end
        endcase
    end

    // One multiplier bit per cycle; the top bit weighs negative, odd passes subtract.
    always_comb
    begin
        mul_term = mplier_reg[0] ? mcand_reg : '0;
        mul_last = (cnt_reg == MB_CNT_W'(MUL_B_W - 1));
        mul_sum  = (mul_last ^ pass_reg[0]) ? acc_reg - mul_term : acc_reg + mul_term;
        var_pos  = !mul_sum[ACC_W-1] && (mul_sum != '0);
        cov_abs  = cov_reg[ACC_W-1] ? (~cov_reg + 1'b1) : cov_reg;
    end

    // Restoring division, one quotient bit per cycle; the divisor sits in acc_reg.
    always_comb
    begin
        div_shift = {rem_reg, num_reg[NUM_W-1]};
        div_diff  = div_shift - {1'b0, acc_reg};
        div_ge    = (div_shift >= {1'b0, acc_reg});
        div_last  = (div_cnt_reg == DIV_CNT_W'(NUM_W - 1));
    end

    // Rounding to nearest, ties away from zero, then saturation.
    always_comb
    begin
        rnd      = ({rem_reg, 1'b0} >= {1'b0, acc_reg});
        quot_rnd = {1'b0, quot_reg} + (QUOT_W + 1)'(rnd);
        quot_neg = ~quot_rnd + 1'b1;
        if (early_reg)
        begin
            fin_slope  = '0;
            fin_status = early_code_reg;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || (quot_rnd > NEG_LIMIT))
            begin
                fin_slope  = SLOPE_MIN;
                fin_status = STATUS_SAT;
            end
            else
            begin
                fin_slope  = quot_neg[SLOPE_W-1:0];
                fin_status = STATUS_OK;
            end
        end
        else if (ovf_reg || (quot_rnd > POS_LIMIT))
        begin
            fin_slope  = SLOPE_MAX;
            fin_status = STATUS_SAT;
        end
        else
        begin
            fin_slope  = quot_rnd[SLOPE_W-1:0];
            fin_status = STATUS_OK;
        end
    end

    assign out_free    = !out_valid_reg || result.ready;
    assign merge_total = (COUNT_BITS + 1)'(count_reg) + (COUNT_BITS + 1)'(head.merge_count);

    // Main sequencer: applies queued requests and runs an evaluation.
    always_comb
    begin
        count_next      = count_reg;
        sum_x_next      = sum_x_reg;
        sum_x2_next     = sum_x2_reg;
        sum_y_next      = sum_y_reg;
        sum_xy_next     = sum_xy_reg;
        state_next      = state_reg;
        pass_next       = pass_reg;
        cnt_next        = cnt_reg;
        div_cnt_next    = div_cnt_reg;
        early_next      = early_reg;
        early_code_next = early_code_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        acc_next        = acc_reg;
        cov_next        = cov_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        slope_next      = slope_reg;
        status_next     = status_reg;
        pop             = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (!qstat.empty)
                begin
                    pop = 1'b1;
                    unique case (head.func)
                        FUNC_ADD:
                        begin
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next  = count_reg + 1'b1;
                                sum_x_next  = sum_x_reg + SUM_X_W'(head.x_value);
                                sum_y_next  = sum_y_reg + SUM_X_W'(head.y_value);
                                sum_x2_next = sum_x2_reg + SUM_X2_W'(head.x_sq);
                                sum_xy_next = sum_xy_reg + SUM_XY_W'(head.x_y);
                            end
                        end
                        FUNC_DROP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next  = count_reg - 1'b1;
                                sum_x_next  = sum_x_reg - SUM_X_W'(head.x_value);
                                sum_y_next  = sum_y_reg - SUM_X_W'(head.y_value);
                                sum_x2_next = sum_x2_reg - SUM_X2_W'(head.x_sq);
                                sum_xy_next = sum_xy_reg - SUM_XY_W'(head.x_y);
                            end
                        end
                        FUNC_MERGE:
                        begin
                            count_next  = merge_total[COUNT_BITS] ? COUNT_MAX
                                                                  : merge_total[COUNT_BITS-1:0];
                            sum_x_next  = sum_x_reg + SUM_X_W'(head.merge_sum_x);
                            sum_y_next  = sum_y_reg + SUM_X_W'(head.merge_sum_y);
                            sum_x2_next = sum_x2_reg + SUM_X2_W'(head.merge_sum_x2);
                            sum_xy_next = sum_xy_reg + SUM_XY_W'(head.merge_sum_xy);
                        end
                        FUNC_CLEAR:
                        begin
                            count_next  = '0;
                            sum_x_next  = '0;
                            sum_y_next  = '0;
                            sum_x2_next = '0;
                            sum_xy_next = '0;
                        end
                        FUNC_EVAL:
                        begin
                            if (count_reg < COUNT_BITS'(2))
                            begin
                                early_next      = 1'b1;
                                early_code_next = STATUS_FEW;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                acc_next    = '0;
                                pass_next   = 2'd0;
                                cnt_next    = '0;
                                mcand_next  = op_mcand;
                                mplier_next = op_mplier;
                                state_next  = ST_MUL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                acc_next = mul_sum;
                if (!mul_last)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                else if (pass_reg != 2'd3)
                begin
                    // Start the next pass; covariance is complete after the second.
                    pass_next   = pass_reg + 2'd1;
                    cnt_next    = '0;
                    mcand_next  = op_mcand;
                    mplier_next = op_mplier;
                    if (pass_reg == 2'd1)
                    begin
                        cov_next = mul_sum;
                        acc_next = '0;
                    end
                end
                else if (var_pos)
                begin
                    num_next     = NUM_W'(cov_abs) << FRACTION_BITS;
                    neg_next     = cov_reg[ACC_W-1];
                    rem_next     = '0;
                    quot_next    = '0;
                    ovf_next     = 1'b0;
                    div_cnt_next = '0;
                    early_next   = 1'b0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    early_next      = 1'b1;
                    early_code_next = STATUS_FLAT;
                    state_next      = ST_FIN;
                end
            end

            ST_DIV:
            begin
                rem_next     = div_ge ? div_diff[ACC_W-1:0] : div_shift[ACC_W-1:0];
                quot_next    = {quot_reg[QUOT_W-2:0], div_ge};
                ovf_next     = ovf_reg || quot_reg[QUOT_W-1];
                num_next     = num_reg << 1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    slope_next     = fin_slope;
                    status_next    = fin_status;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control and aggregate registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_x2_reg     <= '0;
            sum_y_reg      <= '0;
            sum_xy_reg     <= '0;
            state_reg      <= ST_RUN;
            pass_reg       <= 2'd0;
            cnt_reg        <= '0;
            div_cnt_reg    <= '0;
            early_reg      <= 1'b0;
            early_code_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            sum_x_reg      <= sum_x_next;
            sum_x2_reg     <= sum_x2_next;
            sum_y_reg      <= sum_y_next;
            sum_xy_reg     <= sum_xy_next;
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            cnt_reg        <= cnt_next;
            div_cnt_reg    <= div_cnt_next;
            early_reg      <= early_next;
            early_code_reg <= early_code_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        cov_reg    <= cov_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        ovf_reg    <= ovf_next;
        neg_reg    <= neg_next;
        slope_reg  <= slope_next;
        status_reg <= status_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.slope  = slope_reg;
    assign result.status = status_reg;

endmodule

>>> rtl/core/regression_slope_accumulator.sv
// Running least-squares slope accumulator.
//
// Requests arrive on the sample channel (valid/ready). Each one adds a point,
// drops a point, merges a partial aggregate, clears the aggregate or asks for
// an evaluation; unknown function codes are taken and discarded. Only an
// evaluation produces a request on the result channel: the slope in signed
// fixed point with FRACTION_BITS fraction bits, and a status code.
// Requests pass through a four-entry queue into the execution stage. Add, drop,
// merge and clear are applied as they reach the head, one per cycle while no
// evaluation runs. An evaluation with fewer than two points goes straight to
// the result. Otherwise a bit-serial multiplier makes four passes, and a
// restoring divider forms the quotient, one quotient bit per cycle, which is
// then rounded and saturated into the result register.
// Meanwhile up to four further requests are taken into the queue.
// When the receiver stalls, the result waits in its output register; the
// block keeps applying updates up to the next evaluation, whose result then waits.
// Reset clears the count, all sums, the queue and the result valid.
module regression_slope_accumulator import rsa_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rsa_in_if.sink     sample,
    rsa_out_if.source  result
);

    logic   q_push;
    logic   q_pop;
    entry_t q_wr_entry;
    entry_t q_head;
    qstat_t q_stat;

    // Front: accepts and classifies requests.
    rsa_front u_front (
        .sample (sample),
        .qstat  (q_stat),
        .push   (q_push),
        .entry  (q_wr_entry)
    );

    // Queue between the front and the execution stage.
    rsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .qstat    (q_stat)
    );

    // Back: aggregate update and evaluation.
    rsa_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .qstat  (q_stat),
        .pop    (q_pop),
        .result (result)
    );

    // The front never writes into a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("request written into a full queue");

    // The back never takes from an empty queue.
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request taken from an empty queue");

    // A take without a write leaves room in the queue.
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_stat.full)
        else $error("queue still full after a take");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rsa_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int DRAIN_CYCLES    = 400;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASES          = 4;

    // Highest function code; codes above clear are taken and discarded.
    localparam logic [FUNC_W-1:0] FUNC_LAST_SPARE  = 3'd7;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL   = '1;
    localparam logic [SLOPE_W-1:0]    SLOPE_TOP    = 32'h7FFF_FFFF;
    localparam logic [SLOPE_W-1:0]    SLOPE_BOTTOM = 32'h8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [SAMPLE_BITS-1:0]   x_value;
        logic [SAMPLE_BITS-1:0]   y_value;
        logic [MERGE_COUNT_W-1:0] merge_count;
        logic [MERGE_SX_W-1:0]    merge_sum_x;
        logic [MERGE_SX2_W-1:0]   merge_sum_x2;
        logic [MERGE_SX_W-1:0]    merge_sum_y;
        logic [MERGE_SXY_W-1:0]   merge_sum_xy;
    } request_t;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        status_t            status;
    } fit_t;

    logic clk;
    logic rst_n;

    rsa_in_if  smp();
    rsa_out_if res();

    regression_slope_accumulator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res)
    );

    // Requests waiting to be sent; the head is the one on the bus.
    request_t requests_to_send[$];
    // Slopes that the aggregate should yield, oldest first.
    fit_t     expected_fits[$];

    // Own copy of the aggregate, updated in the order requests are taken.
    logic [COUNT_BITS-1:0]      pts;
    logic signed [SUM_X_W-1:0]  acc_x;
    logic signed [SUM_X_W-1:0]  acc_y;
    logic [SUM_X2_W-1:0]        acc_xx;
    logic signed [SUM_XY_W-1:0] acc_xy;

    int  mismatches;
    int  cycle_count;
    int  items_queued;
    int  send_idle_pct;
    int  stall_pct;
    logic req_taken;

    // Points currently believed to be in the sliding window.
    int  window_x[$];
    int  window_y[$];

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Exact slope of the current aggregate, rounded half away from zero.
    function automatic fit_t least_squares_slope();
        fit_t                f;
        logic signed [127:0] n_w;
        logic signed [127:0] sx_w;
        logic signed [127:0] sy_w;
        logic signed [127:0] sxx_w;
        logic signed [127:0] sxy_w;
        logic signed [127:0] cov;
        logic signed [127:0] spread;
        logic [127:0]        num;
        logic [127:0]        quo;
        logic [127:0]        rem;
        logic                neg;
        f.slope = '0;
        if (pts < 2)
        begin
            f.status = STATUS_FEW;
            return f;
        end
        n_w    = pts;
        sx_w   = acc_x;
        sy_w   = acc_y;
        sxx_w  = acc_xx;
        sxy_w  = acc_xy;
        cov    = n_w * sxy_w - sx_w * sy_w;
        spread = n_w * sxx_w - sx_w * sx_w;
        if (spread <= 0)
        begin
            f.status = STATUS_FLAT;
            return f;
        end
        neg = cov < 0;
        num = (neg ? -cov : cov) << FRACTION_BITS_DEF;
        quo = num / spread;
        rem = num % spread;
        if ((rem << 1) >= spread)
            quo = quo + 1;
        f.status = STATUS_OK;
        if (!neg)
        begin
            if (quo > SLOPE_TOP)
            begin
                f.slope  = SLOPE_TOP;
                f.status = STATUS_SAT;
            end
            else
                f.slope = quo[SLOPE_W-1:0];
        end
        else
        begin
            if (quo > SLOPE_BOTTOM)
            begin
                f.slope  = SLOPE_BOTTOM;
                f.status = STATUS_SAT;
            end
            else
                f.slope = -quo[SLOPE_W-1:0];
        end
        return f;
    endfunction

    // Apply one taken request to the aggregate copy.
    function automatic void accumulate_request(request_t r);
        logic signed [PROD_W-1:0] xw;
        logic signed [PROD_W-1:0] yw;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] xy;
        xw = $signed(r.x_value);
        yw = $signed(r.y_value);
        xx = xw * xw;
        xy = xw * yw;
        case (r.func)
            FUNC_ADD:
                if (pts != COUNT_FULL)
                begin
                    acc_x  = acc_x + xw;
                    acc_y  = acc_y + yw;
                    acc_xx = acc_xx + xx;
                    acc_xy = acc_xy + xy;
                    pts    = pts + 1'b1;
                end
            FUNC_DROP:
                if (pts != '0)
                begin
                    acc_x  = acc_x - xw;
                    acc_y  = acc_y - yw;
                    acc_xx = acc_xx - xx;
                    acc_xy = acc_xy - xy;
                    pts    = pts - 1'b1;
                end
            FUNC_MERGE:
            begin
                pts = (r.merge_count > COUNT_FULL - pts) ? COUNT_FULL : pts + r.merge_count;
                acc_x  = acc_x + $signed(r.merge_sum_x);
                acc_y  = acc_y + $signed(r.merge_sum_y);
                acc_xx = acc_xx + r.merge_sum_x2;
                acc_xy = acc_xy + $signed(r.merge_sum_xy);
            end
            FUNC_EVAL:
                expected_fits.push_back(least_squares_slope());
            FUNC_CLEAR:
            begin
                pts    = '0;
                acc_x  = '0;
                acc_y  = '0;
                acc_xx = '0;
                acc_xy = '0;
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [SLOPE_W-1:0] want_slope,
                                 input logic [STATUS_W-1:0] want_status);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch (%s) at cycle %0d: slope exp %h got %h, status exp %0d got %0d",
                     what, cycle_count, want_slope, res.slope, want_status, res.status);
    endtask

    // Rising edge: take requests into the aggregate copy and check results.
    always @(posedge clk)
    begin : monitor
        fit_t want;
        cycle_count <= cycle_count + 1;
        req_taken   <= smp.valid && smp.ready;
        if (rst_n && smp.valid && smp.ready)
        begin
            accumulate_request(requests_to_send[0]);
            void'(requests_to_send.pop_front());
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_fits.size() == 0)
                flag_mismatch("unexpected", 'x, 'x);
            else
            begin
                want = expected_fits.pop_front();
                if (res.slope !== want.slope || res.status !== want.status)
                    flag_mismatch("wrong field", want.slope, want.status);
            end
        end
    end

    // Falling edge: present the next request and decide the receiver stall.
    always @(negedge clk)
    begin : driver
        request_t r;
        if (rst_n)
        begin
            if (!smp.valid || req_taken)
            begin
                if (requests_to_send.size() != 0 && $urandom_range(1, 100) > send_idle_pct)
                begin
                    r = requests_to_send[0];
                    smp.func         <= r.func;
                    smp.x_value      <= r.x_value;
                    smp.y_value      <= r.y_value;
                    smp.merge_count  <= r.merge_count;
                    smp.merge_sum_x  <= r.merge_sum_x;
                    smp.merge_sum_x2 <= r.merge_sum_x2;
                    smp.merge_sum_y  <= r.merge_sum_y;
                    smp.merge_sum_xy <= r.merge_sum_xy;
                    smp.valid        <= 1'b1;
                end
                else
                    smp.valid <= 1'b0;
            end
            res.ready <= $urandom_range(1, 100) > stall_pct;
        end
    end

    // A request of the given function with every other field random within range.
    function automatic request_t random_request(logic [FUNC_W-1:0] f);
        request_t    r;
        logic [31:0] sx_raw;
        logic [31:0] sy_raw;
        logic [46:0] sxy_raw;
        sx_raw  = $urandom;
        sy_raw  = $urandom;
        sxy_raw = 47'({$urandom, $urandom});
        r.func         = f;
        r.x_value      = 16'($urandom);
        r.y_value      = 16'($urandom);
        r.merge_count  = 16'($urandom);
        r.merge_sum_x  = {sx_raw[31], sx_raw};
        r.merge_sum_x2 = {1'b0, 46'({$urandom, $urandom})};
        r.merge_sum_y  = {sy_raw[31], sy_raw};
        r.merge_sum_xy = {sxy_raw[46], sxy_raw};
        return r;
    endfunction

    task automatic queue_request(request_t r);
        requests_to_send.push_back(r);
        items_queued++;
    endtask

    task automatic queue_sample(logic [FUNC_W-1:0] f, int x, int y);
        request_t r;
        r = random_request(f);
        r.x_value = 16'(x);
        r.y_value = 16'(y);
        queue_request(r);
    endtask

    task automatic add_point(int x, int y);
        queue_sample(FUNC_ADD, x, y);
        window_x.push_back(x);
        window_y.push_back(y);
    endtask

    task automatic drop_oldest();
        if (window_x.size() != 0)
        begin
            queue_sample(FUNC_DROP, window_x.pop_front(), window_y.pop_front());
        end
    endtask

    task automatic clear_window();
        queue_sample(FUNC_CLEAR, 0, 0);
        window_x.delete();
        window_y.delete();
    endtask

    // A partial aggregate built from a few real points.
    task automatic merge_partial();
        request_t r;
        int       n;
        int       x;
        int       y;
        longint   sx;
        longint   sy;
        longint   sxx;
        longint   sxy;
        n   = $urandom_range(1, 4);
        sx  = 0;
        sy  = 0;
        sxx = 0;
        sxy = 0;
        for (int k = 0; k < n; k++)
        begin
            x   = $urandom_range(0, 65535) - 32768;
            y   = $urandom_range(0, 65535) - 32768;
            sx  += x;
            sy  += y;
            sxx += longint'(x) * x;
            sxy += longint'(x) * y;
        end
        r = random_request(FUNC_MERGE);
        r.merge_count  = 16'(n);
        r.merge_sum_x  = 33'(sx);
        r.merge_sum_y  = 33'(sy);
        r.merge_sum_x2 = 47'(sxx);
        r.merge_sum_xy = 48'(sxy);
        queue_request(r);
    endtask

    // A well-formed run of points around a random line, ended by an evaluation.
    task automatic window_burst();
        int n;
        int span;
        int gain;
        int x;
        int y;
        if ($urandom_range(0, 5) == 0)
            clear_window();
        n = $urandom_range(1, 10);
        case ($urandom_range(0, 2))
            0: span = 32767;
            1: span = 1000;
            default: span = 20;
        endcase
        gain = $urandom_range(0, 8) - 4;
        for (int k = 0; k < n; k++)
        begin
            x = $urandom_range(0, 2 * span) - span;
            y = gain * x + $urandom_range(0, 2 * span) - span;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            add_point(x, y);
            if (window_x.size() > 8 && $urandom_range(0, 1) == 1)
                drop_oldest();
            if ($urandom_range(0, 9) == 0)
                merge_partial();
        end
        queue_sample(FUNC_EVAL, 0, 0);
    endtask

    // Random requests of any function code, full-range fields.
    task automatic noise_items();
        logic [FUNC_W-1:0] f;
        int                n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
        begin
            f = FUNC_W'($urandom_range(FUNC_ADD, FUNC_LAST_SPARE));
            if (f == FUNC_CLEAR)
                clear_window();
            else
                queue_request(random_request(f));
        end
    endtask

    // Partial aggregates at the edges of the merge field ranges.
    task automatic merge_extremes();
        request_t r;
        r = random_request(FUNC_MERGE);
        r.merge_count  = '1;
        r.merge_sum_x  = 33'h0_8000_0000;
        r.merge_sum_x2 = 47'h4000_0000_0000;
        r.merge_sum_y  = 33'h1_8000_0000;
        r.merge_sum_xy = 48'h4000_0000_0000;
        queue_request(r);
        // A full-count aggregate ignores a further point.
        queue_sample(FUNC_ADD, 7, 9);
        r = random_request(FUNC_MERGE);
        r.merge_count  = '0;
        r.merge_sum_x  = 33'h1_8000_0000;
        r.merge_sum_x2 = '0;
        r.merge_sum_y  = 33'h0_8000_0000;
        r.merge_sum_xy = 48'hC000_0000_0000;
        queue_request(r);
        queue_sample(FUNC_EVAL, 0, 0);
    endtask

    // Timeout.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // Reset, stimulus by phase, and the final verdict.
    initial
    begin : stimulus
        int send_idle_by_phase[PHASES];
        int stall_by_phase[PHASES];
        send_idle_by_phase = '{0, 80, 0, 23};
        stall_by_phase     = '{0, 0, 80, 23};
        rst_n            = 1'b0;
        req_taken        = 1'b0;
        cycle_count      = 0;
        mismatches       = 0;
        items_queued     = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        pts              = '0;
        acc_x            = '0;
        acc_y            = '0;
        acc_xx           = '0;
        acc_xy           = '0;
        smp.valid        = 1'b0;
        smp.func         = FUNC_ADD;
        smp.x_value      = '0;
        smp.y_value      = '0;
        smp.merge_count  = '0;
        smp.merge_sum_x  = '0;
        smp.merge_sum_x2 = '0;
        smp.merge_sum_y  = '0;
        smp.merge_sum_xy = '0;
        res.ready        = 1'b0;

        // Empty aggregate, drop at zero count, then a single point.
        queue_sample(FUNC_EVAL, 0, 0);
        queue_sample(FUNC_DROP, 5, 5);
        queue_sample(FUNC_ADD, -32768, -32768);
        queue_sample(FUNC_EVAL, 0, 0);
        // Two points with the same x leave no variance.
        queue_sample(FUNC_ADD, -32768, 32767);
        queue_sample(FUNC_EVAL, 0, 0);
        // Steep lines saturate both ways; one lands exactly on the bottom.
        queue_sample(FUNC_CLEAR, 0, 0);
        queue_sample(FUNC_ADD, 0, -32768);
        queue_sample(FUNC_ADD, 1, 32767);
        queue_sample(FUNC_EVAL, 0, 0);
        queue_sample(FUNC_CLEAR, 0, 0);
        queue_sample(FUNC_ADD, 0, 32767);
        queue_sample(FUNC_ADD, 1, -32768);
        queue_sample(FUNC_EVAL, 0, 0);
        queue_sample(FUNC_CLEAR, 0, 0);
        queue_sample(FUNC_ADD, 0, 0);
        queue_sample(FUNC_ADD, 1, -32768);
        queue_sample(FUNC_EVAL, 0, 0);
        // Spare code, and a drop of a point that was never added.
        queue_sample(FUNC_LAST_SPARE, 3, 4);
        queue_sample(FUNC_DROP, 32767, 32767);
        merge_extremes();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            items_queued  = 0;
            while (items_queued < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(1, 100) <= 80)
                    window_burst();
                else
                    noise_items();
            end
            while (requests_to_send.size() != 0)
                @(posedge clk);
        end

        while (requests_to_send.size() != 0 || expected_fits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_fits.size() != 0)
        begin
            $display("%0d expected slopes never arrived", expected_fits.size());
            mismatches += expected_fits.size();
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
